// ----- design/sps_pkg.sv -----
package sps_pkg;

  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int PERIOD_WIDTH_DEF = 16;
  localparam int FIELD_W          = 16;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam logic [3:0] RUN_LEN_FULL = 4'd4;
  localparam logic [3:0] RUN_LEN_HALF = 4'd8;

  localparam logic [3:0] PAT_WAVE_FWD [0:3] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [3:0] PAT_WAVE_BWD [0:3] = '{4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [3:0] PAT_FULL_FWD [0:3] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [3:0] PAT_FULL_BWD [0:3] = '{4'hC, 4'h6, 4'h3, 4'h9};
  localparam logic [3:0] PAT_HALF_FWD [0:7] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
  localparam logic [3:0] PAT_HALF_BWD [0:7] =
    '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  typedef struct packed {
    logic is_move;
    logic dir;
    logic runs_zero;
  } item_ctl_t;

  function automatic logic [3:0] run_len(input logic [1:0] mode);
    return (mode == MODE_HALF) ? RUN_LEN_HALF : RUN_LEN_FULL;
  endfunction

  function automatic logic [3:0] pattern(input logic [1:0] mode, input logic dir,
                                         input logic [2:0] idx);
    logic [3:0] pat;
    unique case (mode)
      MODE_HALF: pat = dir ? PAT_HALF_BWD[idx] : PAT_HALF_FWD[idx];
      MODE_FULL: pat = dir ? PAT_FULL_BWD[idx[1:0]] : PAT_FULL_FWD[idx[1:0]];
      default:   pat = dir ? PAT_WAVE_BWD[idx[1:0]] : PAT_WAVE_FWD[idx[1:0]];
    endcase
    return pat;
  endfunction

endpackage

// ----- design/sps_front.sv -----
module sps_front import sps_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic                    in_direction,
  input  logic [FIELD_W-1:0]      in_run_count,
  input  logic [FIELD_W-1:0]      in_hold_ticks,
  input  logic                    q_full,
  output logic                    push,
  output item_ctl_t               ctl,
  output logic [COUNT_WIDTH-1:0]  runs,
  output logic [PERIOD_WIDTH-1:0] hold
);

  logic [PERIOD_WIDTH-1:0] hold_raw;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // cut to the latched widths, zero hold taken as one
  assign runs     = COUNT_WIDTH'(in_run_count);
  assign hold_raw = PERIOD_WIDTH'(in_hold_ticks);
  assign hold     = (hold_raw == '0) ? PERIOD_WIDTH'(1) : hold_raw;

  assign ctl.is_move   = (in_cmd == CMD_MOVE);
  assign ctl.dir       = in_direction;
  assign ctl.runs_zero = (runs == '0);

endmodule

// ----- design/sps_queue.sv -----
module sps_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [0:1];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/sps_back.sv -----
module sps_back import sps_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_wdata,
  input  logic                    q_valid,
  input  item_ctl_t               ctl,
  input  logic [COUNT_WIDTH-1:0]  runs,
  input  logic [PERIOD_WIDTH-1:0] hold,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_coils,
  output logic                    out_busy_res,
  output logic                    out_move_done,
  output logic                    out_rejected
);

  logic [1:0]              mode_r;
  logic                    running_r, running_nxt;
  logic                    dir_r, dir_nxt;
  logic [COUNT_WIDTH-1:0]  runs_left_r, runs_left_nxt;
  logic [2:0]              phase_r, phase_nxt;
  logic [PERIOD_WIDTH-1:0] tick_r, tick_nxt;
  logic [PERIOD_WIDTH-1:0] hold_r, hold_nxt;
  logic [3:0]              coil_r, coil_nxt;
  logic                    done_nxt, rej_nxt;
  logic                    out_valid_r;

  logic [PERIOD_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0]  runs_dec;
  logic [3:0]              phase_inc;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign tick_inc  = tick_r + PERIOD_WIDTH'(1);
  assign runs_dec  = runs_left_r - COUNT_WIDTH'(1);
  assign phase_inc = {1'b0, phase_r} + 4'd1;

  always_comb begin
    running_nxt   = running_r;
    dir_nxt       = dir_r;
    runs_left_nxt = runs_left_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    hold_nxt      = hold_r;
    coil_nxt      = coil_r;
    done_nxt      = 1'b0;
    rej_nxt       = 1'b0;
    if (ctl.is_move) begin
      if (running_r) begin
        rej_nxt = 1'b1;
      end else if (ctl.runs_zero) begin
        done_nxt = 1'b1;
      end else begin
        running_nxt   = 1'b1;
        dir_nxt       = ctl.dir;
        runs_left_nxt = runs;
        hold_nxt      = hold;
        tick_nxt      = '0;
        phase_nxt     = 3'd0;
        coil_nxt      = pattern(mode_r, ctl.dir, 3'd0);
      end
    end else if (running_r) begin
      tick_nxt = tick_inc;
      if (tick_inc >= hold_r || tick_inc == '0) begin
        tick_nxt = '0;
        if (phase_inc >= run_len(mode_r)) begin
          runs_left_nxt = runs_dec;
          if (runs_dec == '0) begin
            running_nxt = 1'b0;
            done_nxt    = 1'b1;
          end else begin
            phase_nxt = 3'd0;
            coil_nxt  = pattern(mode_r, dir_r, 3'd0);
          end
        end else begin
          phase_nxt = phase_inc[2:0];
          coil_nxt  = pattern(mode_r, dir_r, phase_inc[2:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_WAVE;
      running_r   <= 1'b0;
      dir_r       <= 1'b0;
      runs_left_r <= '0;
      phase_r     <= 3'd0;
      tick_r      <= '0;
      hold_r      <= '0;
      coil_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (pop) begin
        running_r   <= running_nxt;
        dir_r       <= dir_nxt;
        runs_left_r <= runs_left_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        hold_r      <= hold_nxt;
        coil_r      <= coil_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      out_coils     <= coil_nxt;
      out_busy_res  <= running_nxt;
      out_move_done <= done_nxt;
      out_rejected  <= rej_nxt;
    end
  end

endmodule

// ----- design/stepper_phase_sequencer_top.sv -----
// Channel   | Ports                                              | Direction
// ----------+----------------------------------------------------+----------
// input     | in_valid in_stall in_cmd in_direction              | in
//           | in_run_count in_hold_ticks                         |
// result    | out_valid out_stall out_coils out_busy_res         | out
//           | out_move_done out_rejected                         |
// config    | cfg_we cfg_wdata (step_mode)                       | in
//
// One transaction per cycle sustained while the result is not stalled; an accepted input
// transaction is written into the queue, then executed into the result register when popped.
// Synchronous active-low reset clears queue, sequencer state and coil state (all off); out_coils is not reset.
// The input stalls only when the queue is full; a stalled result holds.
module stepper_phase_sequencer_top import sps_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_direction,
  input  logic [FIELD_W-1:0] in_run_count,
  input  logic [FIELD_W-1:0] in_hold_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_coils,
  output logic               out_busy_res,
  output logic               out_move_done,
  output logic               out_rejected
);

  localparam int CTL_W  = $bits(item_ctl_t);
  localparam int ITEM_W = CTL_W + COUNT_WIDTH + PERIOD_WIDTH;

  logic                    q_full, push, pop, q_valid;
  item_ctl_t               f_ctl, b_ctl;
  logic [COUNT_WIDTH-1:0]  f_runs, b_runs;
  logic [PERIOD_WIDTH-1:0] f_hold, b_hold;
  logic [ITEM_W-1:0]       q_wdata, q_rdata;

  sps_front #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_direction  (in_direction),
    .in_run_count  (in_run_count),
    .in_hold_ticks (in_hold_ticks),
    .q_full        (q_full),
    .push          (push),
    .ctl           (f_ctl),
    .runs          (f_runs),
    .hold          (f_hold)
  );

  assign q_wdata = {f_ctl, f_runs, f_hold};
  assign {b_ctl, b_runs, b_hold} = q_rdata;

  sps_queue #(
    .W (ITEM_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  sps_back #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .ctl           (b_ctl),
    .runs          (b_runs),
    .hold          (b_hold),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coils     (out_coils),
    .out_busy_res  (out_busy_res),
    .out_move_done (out_move_done),
    .out_rejected  (out_rejected)
  );

endmodule

// ----- design/sps_checker.sv -----
module sps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_coils,
  input logic       out_busy_res,
  input logic       out_move_done,
  input logic       out_rejected
);

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("rejected transaction while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_busy_res)
    else $error("move done but still busy");

  a_done_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_rejected)
    else $error("done and rejected together");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coils))
    else $error("stalled result changed");

endmodule

bind stepper_phase_sequencer_top sps_checker u_sps_checker (.*);

// ----- test/stepper_phase_checker.sv -----
module stepper_phase_checker import sps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_direction,
  input  logic [FIELD_W-1:0] in_run_count,
  input  logic [FIELD_W-1:0] in_hold_ticks,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         out_coils,
  input  logic               out_busy_res,
  input  logic               out_move_done,
  input  logic               out_rejected,
  output int                 errors,
  output int                 pending,
  output int                 moves_done,
  output int                 moves_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
    logic       done;
    logic       rej;
  } coil_state_t;

  coil_state_t coil_states_due[$];

  logic [1:0]                  mode_q;
  logic                        running;
  logic                        dir_q;
  logic [COUNT_WIDTH_DEF-1:0]  runs_left;
  logic [PERIOD_WIDTH_DEF-1:0] tick_cnt;
  logic [PERIOD_WIDTH_DEF-1:0] hold_q;
  logic [2:0]                  phase;
  logic [3:0]                  coil_q;

  function automatic logic [3:0] coil_pattern(input logic [1:0] mode, input logic dir,
                                              input logic [2:0] idx);
    logic [7:0] pair;
    unique case (mode)
      MODE_HALF: return dir ? PAT_HALF_BWD[idx] : PAT_HALF_FWD[idx];
      MODE_FULL: begin
        pair = dir ? ({4'b1100, 4'b1100} >> idx[1:0]) : ({4'b0011, 4'b0011} << idx[1:0]);
        return dir ? pair[3:0] : pair[7:4];
      end
      default: return dir ? (4'b1000 >> idx[1:0]) : (4'b0001 << idx[1:0]);
    endcase
  endfunction

  function automatic coil_state_t next_coil_state(input logic cmd, input logic dir,
                                                  input logic [FIELD_W-1:0] runs,
                                                  input logic [FIELD_W-1:0] hold);
    coil_state_t r;
    logic        done;
    logic        rej;
    int          len;
    done = 1'b0;
    rej  = 1'b0;
    len  = (mode_q == MODE_HALF) ? 8 : 4;
    if (cmd == CMD_MOVE) begin
      if (running) begin
        rej = 1'b1;
      end else if (runs[COUNT_WIDTH_DEF-1:0] == '0) begin
        done = 1'b1;
      end else begin
        running   = 1'b1;
        dir_q     = dir;
        runs_left = runs[COUNT_WIDTH_DEF-1:0];
        hold_q    = (hold[PERIOD_WIDTH_DEF-1:0] == '0) ? PERIOD_WIDTH_DEF'(1)
                                                      : hold[PERIOD_WIDTH_DEF-1:0];
        tick_cnt  = '0;
        phase     = '0;
        coil_q    = coil_pattern(mode_q, dir_q, phase);
      end
    end else if (running) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= hold_q || tick_cnt == '0) begin
        tick_cnt = '0;
        if (int'(phase) + 1 >= len) begin
          runs_left = runs_left - 1'b1;
          if (runs_left == '0) begin
            running = 1'b0;
            done    = 1'b1;
          end else begin
            phase  = '0;
            coil_q = coil_pattern(mode_q, dir_q, phase);
          end
        end else begin
          phase  = phase + 3'd1;
          coil_q = coil_pattern(mode_q, dir_q, phase);
        end
      end
    end
    r.coils = coil_q;
    r.busy  = running;
    r.done  = done;
    r.rej   = rej;
    return r;
  endfunction

  always @(posedge clk) begin
    coil_state_t seen;
    coil_state_t want;
    if (!rst_n) begin
      mode_q    = MODE_WAVE;
      running   = 1'b0;
      dir_q     = 1'b0;
      runs_left = '0;
      tick_cnt  = '0;
      hold_q    = '0;
      phase     = '0;
      coil_q    = '0;
      coil_states_due.delete();
    end else begin
      if (cfg_we) mode_q = cfg_wdata;
      if (out_valid && !out_stall) begin
        seen.coils = out_coils;
        seen.busy  = out_busy_res;
        seen.done  = out_move_done;
        seen.rej   = out_rejected;
        if (coil_states_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result coils %h busy %b done %b rejected %b",
                   $time, seen.coils, seen.busy, seen.done, seen.rej);
        end else begin
          want = coil_states_due.pop_front();
          if (seen.coils !== want.coils) begin
            errors++;
            $display("%0t: coils expected %h, got %h", $time, want.coils, seen.coils);
          end
          if (seen.busy !== want.busy) begin
            errors++;
            $display("%0t: busy_res expected %b, got %b", $time, want.busy, seen.busy);
          end
          if (seen.done !== want.done) begin
            errors++;
            $display("%0t: move_done expected %b, got %b", $time, want.done, seen.done);
          end
          if (seen.rej !== want.rej) begin
            errors++;
            $display("%0t: rejected expected %b, got %b", $time, want.rej, seen.rej);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = next_coil_state(in_cmd, in_direction, in_run_count, in_hold_ticks);
        coil_states_due.push_back(want);
        if (want.done) moves_done++;
        if (want.rej) moves_rejected++;
      end
    end
    pending = coil_states_due.size();
  end

endmodule

// ----- test/stepper_phase_sequencer_top_tb.sv -----
module stepper_phase_sequencer_top_tb import sps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         PHASE_ITEMS = 135;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = CMD_TICK;
  logic               in_direction = 1'b0;
  logic [FIELD_W-1:0] in_run_count = '0;
  logic [FIELD_W-1:0] in_hold_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_coils;
  logic               out_busy_res;
  logic               out_move_done;
  logic               out_rejected;

  logic quiet = 1'b0;
  int   sent;
  int   errors;
  int   pending;
  int   moves_done;
  int   moves_rejected;

  stepper_phase_sequencer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_direction (in_direction),
    .in_run_count (in_run_count),
    .in_hold_ticks(in_hold_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_coils    (out_coils),
    .out_busy_res (out_busy_res),
    .out_move_done(out_move_done),
    .out_rejected (out_rejected)
  );

  stepper_phase_checker u_phase_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_direction  (in_direction),
    .in_run_count  (in_run_count),
    .in_hold_ticks (in_hold_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coils     (out_coils),
    .out_busy_res  (out_busy_res),
    .out_move_done (out_move_done),
    .out_rejected  (out_rejected),
    .errors        (errors),
    .pending       (pending),
    .moves_done    (moves_done),
    .moves_rejected(moves_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 18);
  end

  task automatic send_transaction(input logic cmd, input logic dir,
                                  input logic [FIELD_W-1:0] runs,
                                  input logic [FIELD_W-1:0] hold);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_direction  <= dir;
    in_run_count  <= runs;
    in_hold_ticks <= hold;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_transaction(CMD_TICK, 1'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_step_mode(input logic [1:0] mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic play_move(input logic [1:0] mode);
    int runs;
    int hold;
    int span;
    int extra;
    if ($urandom_range(99) < 85) begin
      runs  = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      hold  = $urandom_range(4);
      span  = runs * ((mode == MODE_HALF) ? 8 : 4) * ((hold == 0) ? 1 : hold);
      extra = $urandom_range(3);
      send_transaction(CMD_MOVE, 1'($urandom), FIELD_W'(runs), FIELD_W'(hold));
      for (int i = 0; i < span + extra; i++) begin
        if (i < span - 1 && $urandom_range(99) < 4)
          send_transaction(CMD_MOVE, 1'($urandom), FIELD_W'($urandom_range(3)),
                           FIELD_W'($urandom_range(4)));
        send_tick();
      end
    end else if ($urandom_range(1) == 1) begin
      send_transaction(CMD_MOVE, 1'($urandom), FIELD_W'($urandom_range(2)),
                       FIELD_W'($urandom_range(3)));
    end else begin
      send_tick();
    end
  endtask

  initial begin
    logic [1:0] mode;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_transaction(CMD_TICK, 1'b0, '0, '0);
    send_transaction(CMD_MOVE, 1'b0, '0, 16'd5);
    send_transaction(CMD_MOVE, 1'b0, 16'd1, '0);
    send_transaction(CMD_MOVE, 1'b1, 16'hA5A5, 16'h5A5A);
    repeat (4) send_tick();

    set_step_mode(MODE_HALF);
    send_transaction(CMD_MOVE, 1'b1, 16'd1, '0);
    repeat (8) send_tick();

    set_step_mode(MODE_FULL);
    send_transaction(CMD_MOVE, 1'b0, 16'd2, 16'd1);
    repeat (8) send_tick();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       mode = MODE_FULL;
        1:       mode = MODE_HALF;
        2:       mode = MODE_SPARE;
        3:       mode = MODE_WAVE;
        default: mode = 2'($urandom);
      endcase
      set_step_mode(mode);
      quiet = (p == 1);
      while (sent < 26 + (p + 1) * PHASE_ITEMS) play_move(mode);
      quiet = 1'b0;
    end

    drain_results();
    repeat (200) send_tick();
    send_transaction(CMD_MOVE, 1'b1, '1, '1);
    repeat (3) send_tick();
    send_transaction(CMD_MOVE, 1'b1, '1, '1);
    drain_results();

    $display("Sent %0d transactions across wave, full, half and spare step modes",
             sent);
    $display("Moves completed: %0d, move commands refused while busy: %0d",
             moves_done, moves_rejected);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
